>>> design/rdm_pkg.sv
// Package for the dot-star pattern matcher: shared constants, item codes and the
// structures carried between the top level and the row of position cells.
// No dependencies.
package rdm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int POS_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 8;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_END  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              any;
    logic              star;
  } tok_t;

  typedef struct packed {
    tok_t              tok;
    logic [CHAR_W-1:0] text_char;
  } bus_t;

  typedef struct packed {
    logic tok_we;
    logic step;
    logic restart;
    logic first;
    logic in_use;
    logic in_pat;
  } ctl_t;

  typedef struct packed {
    logic carry;
    logic adv;
    logic fcarry;
  } link_t;

endpackage

>>> design/rdm_in_if.sv
// Input channel of the pattern matcher: valid/ready handshake with the item fields.
// Depends on rdm_pkg.
interface rdm_in_if;
  import rdm_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  token_index;
  logic [CHAR_W-1:0] token_char;
  logic              token_any;
  logic              token_star;
  logic [CHAR_W-1:0] text_char;
  logic              text_last;

  modport source (
    output valid, mode, token_index, token_char, token_any, token_star, text_char,
           text_last,
    input  ready
  );
  modport sink (
    input  valid, mode, token_index, token_char, token_any, token_star, text_char,
           text_last,
    output ready
  );
endinterface

>>> design/rdm_out_if.sv
// Result channel of the pattern matcher: valid/ready handshake with the match flag.
// No dependencies.
interface rdm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

>>> design/rdm_cell.sv
// One pattern position: holds its token and its active bit, and passes closure,
// advance and final-closure signals to the next position. Depends on rdm_pkg.
module rdm_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rdm_pkg::ctl_t  ctl,
  input  rdm_pkg::bus_t  bus,
  input  rdm_pkg::link_t link_in,
  output rdm_pkg::link_t link_out,
  output logic           active,
  output logic           closed,
  output logic           fclosed
);
  import rdm_pkg::*;

  tok_t tok_r;
  logic act_r;
  logic hit;
  logic take;
  logic nxt;

  always_comb begin
    closed          = (act_r | link_in.carry) & ctl.in_pat;
    hit             = tok_r.any | (tok_r.chr == bus.text_char);
    take            = closed & hit & ctl.in_use;
    link_out.carry  = closed & tok_r.star & ctl.in_use;
    link_out.adv    = take & ~tok_r.star;
    nxt             = (take & tok_r.star) | link_in.adv;
    fclosed         = (nxt | link_in.fcarry) & ctl.in_pat;
    link_out.fcarry = fclosed & tok_r.star & ctl.in_use;
  end

  assign active = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ctl.first;
    end else if (ctl.restart) begin
      act_r <= ctl.first;
    end else if (ctl.step) begin
      act_r <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tok_we) begin
      tok_r <= bus.tok;
    end
  end

endmodule

>>> design/regex_dot_star_matcher_top.sv
// Top level of the dot-star pattern matcher: a row of position cells, the end
// position, the token count register and the result register.
// Depends on rdm_pkg, rdm_in_if, rdm_out_if and rdm_cell.
//
// Usage. Load tokens with mode 0 items on in_ch, one token per transfer, and set
// the number of tokens in use with cfg_we/cfg_wdata while the block is idle.
// Text bytes then arrive as mode 1 items, one per transfer; the byte flagged
// text_last, or a mode 2 item for an empty text, produces one transfer on out_ch
// whose matched flag says whether the whole text matched the whole pattern.
// All pattern positions update together, so an item is taken every cycle,
// whatever its mode. A result appears on out_ch the cycle after the item that
// caused it. The result register decouples the two sides: a new item is taken
// whenever the result register is empty or is being emptied in the same cycle,
// so a receiver that holds ready low stalls the input only while a result waits.
// Reset leaves only the start position active, the token count at zero and no
// result pending; the token store holds nothing defined until written.
module regex_dot_star_matcher_top (
  input  logic                       clk,
  input  logic                       rst_n,
  rdm_in_if.sink                     in_ch,
  rdm_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [rdm_pkg::CNT_W-1:0]  cfg_wdata
);
  import rdm_pkg::*;

  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic [CNT_W-1:0]      count_r;
  logic [POS_W-1:0]      n;
  logic                  out_valid_r;
  logic                  matched_r;
  logic                  in_fire;
  logic                  is_text;
  logic                  is_end;
  logic                  step;
  logic                  restart;
  logic                  res_fire;
  logic                  res_val;
  logic                  act_end_r;
  logic                  closed_end;
  logic                  fclosed_end;
  bus_t                  bus;
  ctl_t                  ctl   [MAX_TOKENS];
  link_t                 link  [MAX_TOKENS+1];
  logic [MAX_TOKENS:0]   act_v;
  logic [MAX_TOKENS:0]   closed_v;
  logic [MAX_TOKENS:0]   fclosed_v;
  logic [MAX_TOKENS:0]   in_pat_v;

  always_comb begin
    if (CMP_W'(count_r) > CMP_W'(MAX_TOKENS)) begin
      n = POS_W'(MAX_TOKENS);
    end else begin
      n = POS_W'(count_r);
    end
  end

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign is_text     = in_ch.mode == MODE_TEXT;
  assign is_end      = in_ch.mode == MODE_END;
  assign step        = in_fire & is_text & ~in_ch.text_last;
  assign restart     = in_fire & (is_end | (is_text & in_ch.text_last));
  assign res_fire    = restart;
  assign res_val     = is_end ? closed_v[n] : fclosed_v[n];

  assign bus.tok.chr   = in_ch.token_char;
  assign bus.tok.any   = in_ch.token_any;
  assign bus.tok.star  = in_ch.token_star;
  assign bus.text_char = in_ch.text_char;

  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      ctl[i].tok_we  = in_fire & (in_ch.mode == MODE_LOAD) &
                       (CMP_W'(in_ch.token_index) == CMP_W'(i));
      ctl[i].step    = step;
      ctl[i].restart = restart;
      ctl[i].first   = (i == 0);
      ctl[i].in_use  = POS_W'(i) < n;
      ctl[i].in_pat  = POS_W'(i) <= n;
    end
  end

  assign link[0] = '0;

  for (genvar g = 0; g < MAX_TOKENS; g++) begin : g_cell
    rdm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .bus      (bus),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .active   (act_v[g]),
      .closed   (closed_v[g]),
      .fclosed  (fclosed_v[g])
    );
    assign in_pat_v[g] = ctl[g].in_pat;
  end

  assign closed_end  = (act_end_r | link[MAX_TOKENS].carry) & (n == POS_W'(MAX_TOKENS));
  assign fclosed_end = (link[MAX_TOKENS].adv | link[MAX_TOKENS].fcarry) &
                       (n == POS_W'(MAX_TOKENS));
  assign closed_v[MAX_TOKENS]  = closed_end;
  assign fclosed_v[MAX_TOKENS] = fclosed_end;
  assign act_v[MAX_TOKENS]     = act_end_r;
  assign in_pat_v[MAX_TOKENS]  = n == POS_W'(MAX_TOKENS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_end_r <= 1'b0;
    end else if (restart) begin
      act_end_r <= 1'b0;
    end else if (step) begin
      act_end_r <= link[MAX_TOKENS].adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      matched_r <= res_val;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = matched_r;

`ifndef SYNTHESIS
  a_restart_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> act_v == (MAX_TOKENS+1)'(1))
    else $error("Active set not back at the start position after a result.");

  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> out_valid_r)
    else $error("Result lost between item transfer and result register.");

  a_load_keeps_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.mode == MODE_LOAD) |=> $stable(act_v))
    else $error("Token load disturbed the active set.");

  a_no_stray_active: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_we) |=> (act_v & ~in_pat_v) == '0)
    else $error("Active position beyond the pattern length after a text byte.");
`endif

endmodule

>>> tb/sv/rdm_match_checker.sv
// Checker for the dot-star pattern matcher: watches the input, result and register
// ports, predicts each match flag and compares it with the transfer on the result channel.
// Depends on rdm_pkg, rdm_in_if and rdm_out_if.
module rdm_match_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  rdm_in_if                         in_ch,
  rdm_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [rdm_pkg::CNT_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rdm_pkg::*;

  localparam int REPORT_LIMIT = 10;

  tok_t                pattern [MAX_TOKENS];
  logic [MAX_TOKENS:0] live_pos;
  logic [CNT_W-1:0]    token_count;
  bit                  expected_matches [$];

  function automatic int tokens_in_use();
    return (token_count > CNT_W'(MAX_TOKENS)) ? MAX_TOKENS : int'(token_count);
  endfunction

  // Starred tokens may match nothing, so activity flows through them; positions past
  // the end of the pattern are dropped.
  function automatic logic [MAX_TOKENS:0] close_positions(logic [MAX_TOKENS:0] s, int n);
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (i < n && s[i] && pattern[i].star) s[i+1] = 1'b1;
    end
    for (int i = 0; i <= MAX_TOKENS; i++) begin
      if (i > n) s[i] = 1'b0;
    end
    return s;
  endfunction

  task automatic note_mismatch(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: matched expected %b, got %b", $time, what, want, got);
    end
  endtask

  task automatic predict_item();
    int                  n;
    logic [MAX_TOKENS:0] cur;
    logic [MAX_TOKENS:0] nxt;
    bit                  hit;
    n = tokens_in_use();
    case (mode_t'(in_ch.mode))
      MODE_LOAD: begin
        pattern[in_ch.token_index] = {in_ch.token_char, in_ch.token_any, in_ch.token_star};
      end
      MODE_END: begin
        cur = close_positions(live_pos, n);
        expected_matches.push_back(cur[n]);
        live_pos = (MAX_TOKENS+1)'(1);
      end
      MODE_TEXT: begin
        cur = close_positions(live_pos, n);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
          hit = pattern[i].any || (pattern[i].chr == in_ch.text_char);
          if (cur[i] && hit) begin
            if (pattern[i].star) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        if (in_ch.text_last) begin
          nxt = close_positions(nxt, n);
          expected_matches.push_back(nxt[n]);
          live_pos = (MAX_TOKENS+1)'(1);
        end else begin
          live_pos = nxt;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    bit want;
    if (!rst_n) begin
      live_pos = (MAX_TOKENS+1)'(1);
      token_count = '0;
      expected_matches.delete();
      mismatches = 0;
      for (int i = 0; i < MAX_TOKENS; i++) pattern[i] = '0;
    end else begin
      // The result of an item is registered and leaves in a later cycle, so the result
      // side is settled before this edge's input transfer is predicted.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_matches.size() == 0) begin
          note_mismatch("result with none expected", 1'bx, out_ch.matched);
        end else begin
          want = expected_matches.pop_front();
          if (out_ch.matched !== want) note_mismatch("wrong match flag", want, out_ch.matched);
        end
      end
      if (cfg_we) token_count = cfg_wdata;
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    outstanding <= expected_matches.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the pattern matcher testbench: clock, reset, token loads, texts and register
// writes, with random idling on both channels, and the final verdict.
// Depends on rdm_pkg, rdm_in_if, rdm_out_if, rdm_match_checker and the matcher top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rdm_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [7:0] FIRST_LETTER = 8'h61;
  localparam int         RANDOM_ITEMS = 1650;
  localparam int         CALM_TAIL    = 150;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               mismatches;
  int               outstanding;

  tok_t       shadow [MAX_TOKENS];
  logic [7:0] text_buf [$];
  int         items_sent;
  int         active_tokens;
  bit         calm;
  bit         sender_gaps;

  rdm_in_if  in_ch ();
  rdm_out_if out_ch ();

  always #5 clk = ~clk;

  regex_dot_star_matcher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rdm_match_checker match_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return FIRST_LETTER + 8'($urandom_range(0, 2));
  endfunction

  function automatic tok_t make_tok(logic [7:0] chr, logic any, logic star);
    tok_t t;
    t.chr  = chr;
    t.any  = any;
    t.star = star;
    return t;
  endfunction

  function automatic tok_t random_tok();
    return make_tok(pick_char(), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return MAX_TOKENS;
      2: return $urandom_range(MAX_TOKENS + 1, 31);
      3, 4, 5: return $urandom_range(1, 4);
      default: return $urandom_range(1, MAX_TOKENS);
    endcase
  endfunction

  // Valid is left high after a transfer; the next item or the caller decides what
  // happens at the following falling edge.
  task automatic transfer_item(input logic [1:0] m, input logic [IDX_W-1:0] idx,
                               input tok_t t, input logic [7:0] tc, input logic last);
    if (sender_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = m;
    in_ch.token_index = idx;
    in_ch.token_char  = t.chr;
    in_ch.token_any   = t.any;
    in_ch.token_star  = t.star;
    in_ch.text_char   = tc;
    in_ch.text_last   = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (m != MODE_UNUSED) items_sent++;
  endtask

  task automatic load_token(input int idx, input tok_t t);
    transfer_item(MODE_LOAD, IDX_W'(idx), t, pick_char(), 1'($urandom_range(0, 1)));
    shadow[idx] = t;
  endtask

  task automatic end_item();
    transfer_item(MODE_END, IDX_W'($urandom_range(0, 15)), random_tok(), pick_char(),
                  1'($urandom_range(0, 1)));
  endtask

  task automatic idle_item();
    transfer_item(MODE_UNUSED, IDX_W'($urandom_range(0, 15)), random_tok(), pick_char(),
                  1'($urandom_range(0, 1)));
  endtask

  task automatic send_bytes(input int from, input int upto, input bit close, input bit noisy);
    for (int i = from; i < upto; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) idle_item();
      transfer_item(MODE_TEXT, IDX_W'($urandom_range(0, 15)), random_tok(), text_buf[i],
                    close && i == upto - 1);
    end
  endtask

  task automatic send_text(input bit noisy);
    if (text_buf.size() == 0) end_item();
    else send_bytes(0, text_buf.size(), 1'b1, noisy);
  endtask

  task automatic build_matching_text();
    int reps;
    text_buf.delete();
    for (int i = 0; i < active_tokens; i++) begin
      reps = shadow[i].star ? $urandom_range(0, 3) : 1;
      repeat (reps) text_buf.push_back(shadow[i].any ? pick_char() : shadow[i].chr);
    end
  endtask

  task automatic build_random_text();
    text_buf.delete();
    repeat ($urandom_range(0, 6)) text_buf.push_back(pick_char());
  endtask

  task automatic mutate_text();
    int n;
    n = text_buf.size();
    case ($urandom_range(0, 2))
      0: if (n > 0) text_buf[$urandom_range(0, n - 1)] = pick_char();
      1: if (n > 0) text_buf.delete($urandom_range(0, n - 1));
      default: text_buf.insert($urandom_range(0, n), pick_char());
    endcase
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_count(input int v);
    wait_drain();
    repeat (3) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = CNT_W'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    active_tokens = (v > MAX_TOKENS) ? MAX_TOKENS : v;
  endtask

  initial begin
    int k;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_LOAD;
    in_ch.token_index = '0;
    in_ch.token_char  = '0;
    in_ch.token_any   = 1'b0;
    in_ch.token_star  = 1'b0;
    in_ch.text_char   = '0;
    in_ch.text_last   = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    calm              = 1'b0;
    sender_gaps       = 1'b1;
    items_sent        = 0;
    active_tokens     = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Every position is written before any text is streamed.
    load_token(0, make_tok(8'h00, 1'b0, 1'b0));
    load_token(1, make_tok(8'hFF, 1'b0, 1'b1));
    load_token(2, make_tok(8'h5A, 1'b1, 1'b0));
    load_token(3, make_tok(8'hA5, 1'b1, 1'b1));
    for (int i = 4; i < MAX_TOKENS; i++) load_token(i, random_tok());

    write_count(0);
    text_buf.delete();
    send_text(1'b0);
    text_buf = '{FIRST_LETTER};
    send_text(1'b0);

    write_count(4);
    text_buf = '{8'h00, 8'h41};
    send_text(1'b0);
    text_buf = '{8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34};
    send_text(1'b0);
    text_buf = '{8'h00};
    send_text(1'b0);
    text_buf.delete();
    send_text(1'b0);
    text_buf = '{8'hFF, 8'h00, 8'h41};
    send_text(1'b0);
    idle_item();
    text_buf = '{8'h00, 8'h7F, 8'h80};
    send_bytes(0, 1, 1'b0, 1'b0);
    idle_item();
    send_bytes(1, 3, 1'b1, 1'b0);
    text_buf = '{8'h00, 8'h41};
    send_bytes(0, 2, 1'b0, 1'b0);
    end_item();
    text_buf = '{8'h00, 8'h7A};
    send_bytes(0, 1, 1'b0, 1'b0);
    load_token(2, make_tok(8'h7A, 1'b0, 1'b0));
    send_bytes(1, 2, 1'b1, 1'b0);

    write_count(31);
    build_matching_text();
    send_text(1'b0);
    write_count(MAX_TOKENS);
    build_matching_text();
    send_text(1'b0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = (items_sent >= RANDOM_ITEMS - CALM_TAIL);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (!calm && $urandom_range(0, 2) != 0) write_count(pick_count());
      repeat ($urandom_range(0, 3)) load_token($urandom_range(0, MAX_TOKENS - 1), random_tok());
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            build_matching_text();
            send_text(1'b0);
          end
          3: begin
            build_matching_text();
            send_text(1'b1);
          end
          4, 5: begin
            build_matching_text();
            mutate_text();
            send_text(1'b0);
          end
          6: begin
            build_random_text();
            send_text(1'b0);
          end
          7: begin
            build_matching_text();
            send_bytes(0, $urandom_range(0, text_buf.size()), 1'b0, 1'b0);
            end_item();
          end
          8: begin
            build_matching_text();
            k = $urandom_range(0, text_buf.size());
            send_bytes(0, k, 1'b0, 1'b0);
            load_token($urandom_range(0, MAX_TOKENS - 1), random_tok());
            if (k == text_buf.size()) end_item();
            else send_bytes(k, text_buf.size(), 1'b1, 1'b0);
          end
          default: begin
            build_random_text();
            send_text(1'b1);
          end
        endcase
      end
    end

    wait_drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rdm_pkg.sv
design/rdm_in_if.sv
design/rdm_out_if.sv
design/rdm_cell.sv
design/regex_dot_star_matcher_top.sv
tb/sv/rdm_match_checker.sv
tb/sv/tb_top.sv
